>>> sv/kvt_pkg.sv
package kvt_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    // Operation token that walks down the chain, one cell per cycle.
    typedef struct packed {
        logic                  valid;
        kind_t                 kind;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic                  hit;
        logic                  claimed;
    } token_t;

    // End-of-scan broadcast that settles a tentative slot claim.
    typedef struct packed {
        logic valid;
        logic keep;
    } finish_t;

endpackage

>>> sv/kvt_cell.sv
module kvt_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  kvt_pkg::token_t  token_in,
    input  kvt_pkg::finish_t finish,
    output kvt_pkg::token_t  token_out
);
    import kvt_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic                  claim_reg;
    logic                  claim_next;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    token_t                token_reg;
    token_t                token_next;
    logic                  hit;
    logic                  take;

    // A cell matches only while it holds a live entry, so an unwritten key is never compared.
    assign hit  = token_in.valid && valid_reg && (token_in.kind != KIND_CLEAR)
                  && (key_reg == token_in.key);
    // The first free cell seen by an add without a match so far takes the key tentatively.
    assign take = token_in.valid && (token_in.kind == KIND_ADD) && !valid_reg
                  && !token_in.claimed && !token_in.hit;

    always_comb
    begin
        token_next         = token_in;
        token_next.hit     = token_in.hit | hit;
        token_next.claimed = token_in.claimed | take;
        if (hit && (token_in.kind == KIND_SEARCH))
        begin
            token_next.value = value_reg;
        end

        valid_next = valid_reg;
        claim_next = claim_reg;
        if (finish.valid)
        begin
            if (claim_reg && finish.keep)
            begin
                valid_next = 1'b1;
            end
            claim_next = 1'b0;
        end
        if (token_in.valid)
        begin
            if (token_in.kind == KIND_CLEAR)
            begin
                valid_next = 1'b0;
            end
            else if (hit && (token_in.kind == KIND_REMOVE))
            begin
                valid_next = 1'b0;
            end
            if (take)
            begin
                claim_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            claim_reg <= 1'b0;
            token_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            claim_reg <= claim_next;
            token_reg <= token_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            key_reg   <= token_in.key;
            value_reg <= token_in.value;
        end
        else if (hit && (token_in.kind == KIND_ADD))
        begin
            value_reg <= token_in.value;
        end
    end

    assign token_out = token_reg;

endmodule

>>> sv/key_value_table_core.sv
// Associative key/value table built as a chain of storage cells.
//
// Input channel (in_valid/in_ready) takes one operation per transfer: kind
// selects add-or-update, search, remove or clear all; key and new_value
// carry the operands. Output channel (out_valid/out_ready) returns exactly
// one result per operation: found, read_value, entry_count and rejected.
//
// An accepted operation is launched as a token into the first cell and moves
// one cell per cycle. Each cell compares its own key, updates or frees its
// entry, or tentatively claims itself as the free slot for a new key. After
// the token leaves the last cell, a one-cycle broadcast commits or drops the
// claim, and the result is registered. A new operation is accepted the cycle
// after the result register is loaded, so only one operation is in the
// chain at a time.
//
// The result register lets the next operation be accepted and scanned while
// a result still waits; a finished scan then holds until the receiver takes
// the earlier result. Reset clears all valid marks and the entry count.
module key_value_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [31:0] key,
    input  logic [31:0] new_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [31:0] read_value,
    output logic [4:0]  entry_count,
    output logic        rejected
);
    import kvt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    state_t                state_reg;
    token_t                launch_reg;
    token_t                done_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  out_valid_reg;
    logic                  found_reg;
    logic [31:0]           read_value_reg;
    logic                  rejected_reg;

    // chain_tok[i] feeds cell i; chain_tok[ENTRIES] is the token leaving the chain.
    token_t                chain_tok [ENTRIES+1];
    finish_t               finish;
    logic                  room;
    logic                  keep;

    assign chain_tok[0] = launch_reg;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            kvt_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .token_in  (chain_tok[gi]),
                .finish    (finish),
                .token_out (chain_tok[gi+1])
            );
        end
    endgenerate

    // The result register has room when empty or when its result is taken now.
    assign room = !out_valid_reg || out_ready;

    // A claim is kept only when the whole chain saw no existing copy of the key.
    assign keep = (done_reg.kind == KIND_ADD) && done_reg.claimed && !done_reg.hit;

    assign finish.valid = (state_reg == ST_HOLD) && room;
    assign finish.keep  = keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            launch_reg     <= '0;
            done_reg       <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            read_value_reg <= '0;
            rejected_reg   <= 1'b0;
        end
        else
        begin
            // The token is live only in the cycle after the input transfer.
            launch_reg.valid <= (state_reg == ST_IDLE) && in_valid;
            if (out_valid_reg && out_ready && !finish.valid)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        launch_reg.kind    <= kind_t'(kind);
                        launch_reg.key     <= key[KEY_BITS-1:0];
                        launch_reg.value   <= new_value[VALUE_BITS-1:0];
                        launch_reg.hit     <= 1'b0;
                        launch_reg.claimed <= 1'b0;
                        state_reg          <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (chain_tok[ENTRIES].valid)
                    begin
                        done_reg  <= chain_tok[ENTRIES];
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (room)
                    begin
                        out_valid_reg <= 1'b1;
                        found_reg     <= done_reg.hit;
                        if ((done_reg.kind == KIND_SEARCH) && done_reg.hit)
                        begin
                            read_value_reg <= 32'(done_reg.value);
                        end
                        else
                        begin
                            read_value_reg <= '0;
                        end
                        rejected_reg <= (done_reg.kind == KIND_ADD) && !done_reg.hit
                                        && !done_reg.claimed;
                        if (done_reg.kind == KIND_CLEAR)
                        begin
                            count_reg <= '0;
                        end
                        else if (keep)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        else if ((done_reg.kind == KIND_REMOVE) && done_reg.hit
                                 && (count_reg != '0))
                        begin
                            count_reg <= count_reg - 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign read_value  = read_value_reg;
    assign entry_count = 5'(count_reg);
    assign rejected    = rejected_reg;

endmodule
